// ===== rtl/mtp_pkg.sv =====
// shared types, constants and the arctangent table for the move-to-pose steering core
// used by mtp_cordic and move_to_pose_steering_core; no dependencies
package mtp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CW = 62;   // cordic x/y width
	localparam int ZW = 34;   // cordic angle accumulator width, q4.30
	localparam int SW = 5;    // step counter width

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

	typedef enum logic [1:0] {
		DIR_UNDECIDED = 2'd0,
		DIR_FORWARD   = 2'd1,
		DIR_REVERSE   = 2'd2
	} dir_t;

	typedef enum logic [3:0] {
		REG_GAIN_DISTANCE = 4'd0,
		REG_GAIN_ALPHA    = 4'd1,
		REG_GAIN_BETA     = 4'd2,
		REG_TARGET_X      = 4'd3,
		REG_TARGET_Y      = 4'd4,
		REG_SPEED_FLOOR   = 4'd5,
		REG_SPEED_CEILING = 4'd6,
		REG_STEER_LIMIT   = 4'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_BETA,
		ST_BETA_WAIT,
		ST_OMA,
		ST_OMB,
		ST_SPEED,
		ST_STEER,
		ST_STEER_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [15:0] angle;
	} cordic_rsp_t;

	// atan(2^-i) in q2.30, rounded to nearest
	function automatic logic [31:0] atan_q30(input logic [SW-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'h3243F6A9;
			5'd1: v = 32'h1DAC6705;
			5'd2: v = 32'h0FADBAFD;
			5'd3: v = 32'h07F56EA7;
			5'd4: v = 32'h03FEAB77;
			5'd5: v = 32'h01FFD55C;
			5'd6: v = 32'h00FFFAAB;
			5'd7: v = 32'h007FFF55;
			5'd8: v = 32'h003FFFEB;
			5'd9: v = 32'h001FFFFD;
			default: v = 32'd1 << (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/mtp_cordic.sv =====
// iterative cordic vectoring unit: atan2(y, x) rounded to q3.13, one step per cycle
// depends on mtp_pkg
module mtp_cordic (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtp_pkg::cordic_req_t req,
	output mtp_pkg::cordic_rsp_t rsp
);

	logic signed [mtp_pkg::CW-1:0] x_q, y_q, xs, ys, rx, ry;
	logic signed [mtp_pkg::ZW-1:0] z_q, zr, tab;
	logic [mtp_pkg::SW-1:0] i_q;
	logic run_q, done_q;

	assign rx = req.x;
	assign ry = req.y;
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign tab = mtp_pkg::ZW'({2'b00, mtp_pkg::atan_q30(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				i_q <= '0;
				if (rx == '0 && ry == '0) begin
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == mtp_pkg::SW'(mtp_pkg::CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			if (rx == '0 && ry == '0) begin
				x_q <= rx;
				y_q <= ry;
				z_q <= '0;
			end else if (rx < 0) begin
				// rotate into the right half plane first
				if (ry >= 0) begin
					x_q <= ry;
					y_q <= -rx;
					z_q <= mtp_pkg::HALF_PI_Q30;
				end else begin
					x_q <= -ry;
					y_q <= rx;
					z_q <= -mtp_pkg::HALF_PI_Q30;
				end
			end else begin
				x_q <= rx;
				y_q <= ry;
				z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

	always_comb begin
		zr = (z_q + mtp_pkg::ZW'(65536)) >>> 17;
		rsp.done = done_q;
		if (zr > mtp_pkg::ZW'(mtp_pkg::PI_Q13)) begin
			rsp.angle = mtp_pkg::PI_Q13;
		end else if (zr < -mtp_pkg::ZW'(mtp_pkg::PI_Q13)) begin
			rsp.angle = -mtp_pkg::PI_Q13;
		end else begin
			rsp.angle = zr[15:0];
		end
	end

endmodule

// ===== rtl/move_to_pose_steering_core.sv =====
// move-to-pose polar steering controller, top level
// depends on mtp_pkg and mtp_cordic
//
// One pose word in gives one command word out. A word goes from acceptance to a valid
// result through these steps, with the steering pass skipped when the speed rounds to zero:
// the squares of dx and dy on the multiplier for the squared distance, the bit-by-bit
// square root, two passes of the shared cordic unit for the bearing and the steering
// angle, three products on the shared 26x26 multiplier for the gains, a step to pick the
// steering path and one to load the output. s_tready is high only while the core is
// idle, so a new pose is taken only after the result is loaded and the core is back in
// idle. A finished result waits in the output register while the next pose is taken; the
// core holds its next result until that register is free. The first pose after reset
// latches the travel direction, which configuration writes keep.
module move_to_pose_steering_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pose_x[23:0], pose_y[47:24], heading[63:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // steer_angle[14:0], speed_cmd[38:15], zero pad[39]
	output logic [1:0]  m_tuser,   // zero_speed_fault[0], going_reverse[1]
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	mtp_pkg::state_t state_q, state_d;
	mtp_pkg::dir_t dir_q, dir_n;
	mtp_pkg::cordic_req_t creq;
	mtp_pkg::cordic_rsp_t crsp;

	logic signed [15:0] k_rho_q, k_al_q, k_be_q;
	logic signed [23:0] tx_q, ty_q, floor_q, ceil_q;
	logic [13:0] lim_q;

	logic signed [15:0] th_q;
	logic signed [24:0] dx_q, dy_q;
	logic signed [51:0] acc_q, prod;
	logic signed [25:0] mul_a, mul_b;
	logic [26:0] rem_q;
	logic [28:0] rem_n, trial;
	logic [24:0] root_q;
	logic [4:0] cnt_q;
	logic signed [14:0] alpha_q;
	logic signed [17:0] beta_q, beta_w, alpha_w;
	logic signed [15:0] ang;
	logic signed [33:0] omega_q, omega_w;
	logic signed [29:0] speed_q, speed_w, mag;
	logic signed [15:0] steer_q, steer_c, lim_s;
	logic signed [29:0] speed_c;
	logic fault_q, rev_q, rev_n;
	logic out_valid_q;

	logic signed [23:0] in_x, in_y;
	assign in_x = s_tdata[23:0];
	assign in_y = s_tdata[47:24];

	assign s_tready = (state_q == mtp_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_rho_q <= 16'sd4096;
			k_al_q  <= 16'sd4096;
			k_be_q  <= 16'sd0;
			tx_q    <= 24'sd0;
			ty_q    <= 24'sd0;
			floor_q <= 24'sd0;
			ceil_q  <= 24'sd4096;
			lim_q   <= 14'd6434;
		end else if (cfg_we) begin
			case (cfg_index)
				mtp_pkg::REG_GAIN_DISTANCE: k_rho_q <= cfg_data[15:0];
				mtp_pkg::REG_GAIN_ALPHA:    k_al_q  <= cfg_data[15:0];
				mtp_pkg::REG_GAIN_BETA:     k_be_q  <= cfg_data[15:0];
				mtp_pkg::REG_TARGET_X:      tx_q    <= cfg_data;
				mtp_pkg::REG_TARGET_Y:      ty_q    <= cfg_data;
				mtp_pkg::REG_SPEED_FLOOR:   floor_q <= cfg_data;
				mtp_pkg::REG_SPEED_CEILING: ceil_q  <= cfg_data;
				mtp_pkg::REG_STEER_LIMIT:   lim_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	mtp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign prod = mul_a * mul_b;
	assign ang = crsp.angle;

	// root step: bring down two radicand bits, try subtracting 4*root+1
	assign rem_n = {rem_q, acc_q[49:48]};
	assign trial = {2'b00, root_q, 2'b01};

	// bearing, angle of approach and travel direction from the first cordic pass
	always_comb begin
		beta_w  = -18'(ang);
		alpha_w = -18'(th_q) - beta_w;
		dir_n   = dir_q;
		if (dir_q == mtp_pkg::DIR_UNDECIDED) begin
			dir_n = (floor_q < 0 && (alpha_w > 18'(mtp_pkg::HALF_PI_Q13) ||
				alpha_w < -18'(mtp_pkg::HALF_PI_Q13))) ?
				mtp_pkg::DIR_REVERSE : mtp_pkg::DIR_FORWARD;
		end
		rev_n = (dir_n == mtp_pkg::DIR_REVERSE);
	end

	always_comb begin
		speed_w = 30'((prod + 52'sd2048) >>> 12);
		if (rev_q) begin
			speed_w = -speed_w;
		end
		omega_w = rev_q ? -acc_q[33:0] : acc_q[33:0];
		mag = (speed_q < 0) ? -speed_q : speed_q;
	end

	// next state, multiplier operands and cordic requests
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		creq.start = 1'b0;
		creq.x = '0;
		creq.y = '0;
		case (state_q)
			mtp_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = mtp_pkg::ST_SQX;
				end
			end
			mtp_pkg::ST_SQX: begin
				mul_a = 26'(dx_q);
				mul_b = 26'(dx_q);
				state_d = mtp_pkg::ST_SQY;
			end
			mtp_pkg::ST_SQY: begin
				mul_a = 26'(dy_q);
				mul_b = 26'(dy_q);
				state_d = mtp_pkg::ST_ROOT;
			end
			mtp_pkg::ST_ROOT: begin
				if (cnt_q == 5'd24) begin
					state_d = mtp_pkg::ST_BETA;
				end
			end
			mtp_pkg::ST_BETA: begin
				creq.start = 1'b1;
				if (dir_q == mtp_pkg::DIR_REVERSE) begin
					creq.x = mtp_pkg::CW'(dx_q) <<< 20;
					creq.y = mtp_pkg::CW'(dy_q) <<< 20;
				end else begin
					creq.x = -(mtp_pkg::CW'(dx_q) <<< 20);
					creq.y = -(mtp_pkg::CW'(dy_q) <<< 20);
				end
				state_d = mtp_pkg::ST_BETA_WAIT;
			end
			mtp_pkg::ST_BETA_WAIT: begin
				if (crsp.done) begin
					state_d = mtp_pkg::ST_OMA;
				end
			end
			mtp_pkg::ST_OMA: begin
				mul_a = 26'(k_al_q);
				mul_b = 26'(alpha_q);
				state_d = mtp_pkg::ST_OMB;
			end
			mtp_pkg::ST_OMB: begin
				mul_a = 26'(k_be_q);
				mul_b = 26'(beta_q);
				state_d = mtp_pkg::ST_SPEED;
			end
			mtp_pkg::ST_SPEED: begin
				mul_a = 26'(k_rho_q);
				mul_b = {1'b0, root_q};
				state_d = mtp_pkg::ST_STEER;
			end
			mtp_pkg::ST_STEER: begin
				if (speed_q == '0) begin
					state_d = mtp_pkg::ST_OUT;
				end else begin
					creq.start = 1'b1;
					creq.x = mtp_pkg::CW'(mag) <<< 29;
					creq.y = mtp_pkg::CW'(omega_q) <<< 16;
					state_d = mtp_pkg::ST_STEER_WAIT;
				end
			end
			mtp_pkg::ST_STEER_WAIT: begin
				if (crsp.done) begin
					state_d = mtp_pkg::ST_OUT;
				end
			end
			mtp_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					state_d = mtp_pkg::ST_IDLE;
				end
			end
			default: state_d = mtp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtp_pkg::ST_IDLE;
			dir_q   <= mtp_pkg::DIR_UNDECIDED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mtp_pkg::ST_BETA_WAIT && crsp.done) begin
				dir_q <= dir_n;
			end
			if (state_q == mtp_pkg::ST_OUT && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output clamps
	always_comb begin
		lim_s = {2'b00, lim_q};
		steer_c = steer_q;
		if (steer_c > lim_s) begin
			steer_c = lim_s;
		end
		if (steer_c < -lim_s) begin
			steer_c = -lim_s;
		end
		speed_c = speed_q;
		if (speed_c < 30'(floor_q)) begin
			speed_c = 30'(floor_q);
		end
		if (speed_c > 30'(ceil_q)) begin
			speed_c = 30'(ceil_q);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mtp_pkg::ST_IDLE: begin
				th_q <= s_tdata[63:48];
				dx_q <= 25'(in_x) - 25'(tx_q);
				dy_q <= 25'(in_y) - 25'(ty_q);
			end
			mtp_pkg::ST_SQX: acc_q <= prod;
			mtp_pkg::ST_SQY: begin
				acc_q  <= acc_q + prod;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			mtp_pkg::ST_ROOT: begin
				acc_q <= acc_q <<< 2;
				cnt_q <= cnt_q + 1'b1;
				if (rem_n >= trial) begin
					rem_q  <= 27'(rem_n - trial);
					root_q <= {root_q[23:0], 1'b1};
				end else begin
					rem_q  <= rem_n[26:0];
					root_q <= {root_q[23:0], 1'b0};
				end
			end
			mtp_pkg::ST_BETA_WAIT: begin
				if (crsp.done) begin
					rev_q  <= rev_n;
					beta_q <= beta_w + 18'(th_q);
					if (alpha_w > 18'(mtp_pkg::HALF_PI_Q13)) begin
						alpha_q <= 15'(mtp_pkg::HALF_PI_Q13);
					end else if (alpha_w < -18'(mtp_pkg::HALF_PI_Q13)) begin
						alpha_q <= -15'(mtp_pkg::HALF_PI_Q13);
					end else begin
						alpha_q <= alpha_w[14:0];
					end
				end
			end
			mtp_pkg::ST_OMA: acc_q <= prod;
			mtp_pkg::ST_OMB: acc_q <= acc_q + prod;
			mtp_pkg::ST_SPEED: begin
				speed_q <= speed_w;
				omega_q <= omega_w;
			end
			mtp_pkg::ST_STEER: begin
				fault_q <= (speed_q == '0);
				if (omega_q > 0) begin
					steer_q <= mtp_pkg::HALF_PI_Q13;
				end else if (omega_q < 0) begin
					steer_q <= -mtp_pkg::HALF_PI_Q13;
				end else begin
					steer_q <= '0;
				end
			end
			mtp_pkg::ST_STEER_WAIT: begin
				if (crsp.done) begin
					steer_q <= ang;
				end
			end
			mtp_pkg::ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					m_tdata <= {1'b0, speed_c[23:0], steer_c[14:0]};
					m_tuser <= {rev_q, fault_q};
				end
			end
			default: ;
		endcase
	end

endmodule
